// File: hdl/srq_pkg.sv
// shared constants and codes for the strict priority ready queue
package srq_pkg;

  localparam int LEVELS_DEF      = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TASK_BITS_DEF   = 16;

  localparam int CMD_W    = 1;
  localparam int TASK_W   = 16;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// File: hdl/srq_if.sv
// valid/ready channels for commands and results
interface srq_in_if import srq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TASK_W-1:0] task_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, command, task_id, priority_req, input ready);
  modport sink   (input valid, command, task_id, priority_req, output ready);
endinterface

interface srq_out_if import srq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TASK_W-1:0]   task_out;
  logic [PRIO_W-1:0]   level_out;

  modport source (output valid, status, task_out, level_out, input ready);
  modport sink   (input valid, status, task_out, level_out, output ready);
endinterface

// File: hdl/srq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module srq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/strict_priority_ready_queue_core.sv
// strict priority ready queue: per-level fifo pointers and task words held in rams
// result word: the pointer ram is read, then the result is registered out for an enqueue or
//   empty dispatch; a dispatch that returns a task reads the task ram in between
// commands are processed one at a time through the read-modify-write of the pointer ram;
//   no new command is accepted until the result is loaded into the output register
// reset: synchronous active-low; levels read empty, valid bits cleared, task ram kept
module strict_priority_ready_queue_core import srq_pkg::*; #(
  parameter int LEVELS      = LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TASK_BITS   = TASK_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  srq_in_if.sink    in_ch,
  srq_out_if.source out_ch
);

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int TDEPTH  = LEVELS * QUEUE_DEPTH;
  localparam int TADDR_W = $clog2(TDEPTH);

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [CNT_W-1:0] count;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_TASK,
    S_PUT
  } state_t;

  state_t               state_r;
  cmd_t                 cmd_r;
  logic [TASK_BITS-1:0] task_r;
  logic [LVL_W-1:0]     lvl_r;
  logic                 bad_lvl_r;
  logic                 found_r;
  logic [LEVELS-1:0]    ne_r;
  logic [LEVELS-1:0]    meta_vld_r;

  logic [STATUS_W-1:0]  res_status_r;
  logic [TASK_W-1:0]    res_task_r;
  logic [PRIO_W-1:0]    res_level_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [TASK_W-1:0]    out_task_r;
  logic [PRIO_W-1:0]    out_level_r;

  logic                 in_acc;
  logic                 out_free;
  logic                 enc_found;
  logic [LVL_W-1:0]     enc_lvl;
  logic [LVL_W-1:0]     acc_lvl;

  logic                 meta_we;
  logic [META_W-1:0]    meta_rdata;
  meta_t                meta_cur;
  meta_t                meta_nxt;
  logic                 enq_ok;
  logic                 deq_go;
  logic [TADDR_W-1:0]   tbase;
  logic                 task_we;
  logic                 task_re;
  logic [TADDR_W-1:0]   task_waddr;
  logic [TADDR_W-1:0]   task_raddr;
  logic [TASK_BITS-1:0] task_rdata;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.task_out = out_task_r;
  assign out_ch.level_out = out_level_r;

  // lowest-numbered non-empty level
  always_comb begin
    enc_found = 1'b0;
    enc_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne_r[i]) begin
        enc_found = 1'b1;
        enc_lvl   = LVL_W'(i);
      end
    end
  end

  assign acc_lvl = (cmd_t'(in_ch.command) == CMD_ENQUEUE) ? LVL_W'(in_ch.priority_req)
                                                         : enc_lvl;

  // a level whose pointers were never written reads as empty
  assign meta_cur = meta_vld_r[lvl_r] ? meta_t'(meta_rdata) : '0;
  assign enq_ok   = (state_r == S_META) && (cmd_r == CMD_ENQUEUE) && !bad_lvl_r &&
                    (meta_cur.count != CNT_W'(QUEUE_DEPTH));
  assign deq_go   = (state_r == S_META) && (cmd_r == CMD_DISPATCH) && found_r;
  assign meta_we  = enq_ok || deq_go;

  always_comb begin
    meta_nxt = meta_cur;
    if (cmd_r == CMD_ENQUEUE) begin
      meta_nxt.tail  = (meta_cur.tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : meta_cur.tail + 1'b1;
      meta_nxt.count = meta_cur.count + 1'b1;
    end else begin
      meta_nxt.head  = (meta_cur.head == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : meta_cur.head + 1'b1;
      meta_nxt.count = meta_cur.count - 1'b1;
    end
  end

  assign tbase      = TADDR_W'(lvl_r) * TADDR_W'(QUEUE_DEPTH);
  assign task_we    = enq_ok;
  assign task_re    = deq_go;
  assign task_waddr = tbase + TADDR_W'(meta_cur.tail);
  assign task_raddr = tbase + TADDR_W'(meta_cur.head);

  srq_ram #(
    .WIDTH (META_W),
    .DEPTH (LEVELS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (lvl_r),
    .wdata (meta_nxt),
    .re    (in_acc),
    .raddr (acc_lvl),
    .rdata (meta_rdata)
  );

  srq_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (TDEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (task_we),
    .waddr (task_waddr),
    .wdata (task_r),
    .re    (task_re),
    .raddr (task_raddr),
    .rdata (task_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ne_r        <= '0;
      meta_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_PUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (meta_we) begin
        meta_vld_r[lvl_r] <= 1'b1;
        ne_r[lvl_r]       <= (meta_nxt.count != '0);
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_META;
          end
        end
        S_META: begin
          state_r <= (deq_go) ? S_TASK : S_PUT;
        end
        S_TASK: begin
          state_r <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= cmd_t'(in_ch.command);
      task_r    <= TASK_BITS'(in_ch.task_id);
      lvl_r     <= acc_lvl;
      bad_lvl_r <= (32'(in_ch.priority_req) >= 32'(LEVELS));
      found_r   <= enc_found;
    end
    if (state_r == S_META) begin
      res_task_r  <= '0;
      res_level_r <= (cmd_r == CMD_DISPATCH && found_r) ? PRIO_W'(lvl_r) : '0;
      if (cmd_r == CMD_ENQUEUE) begin
        res_status_r <= enq_ok ? ST_DONE : ST_FULL;
      end else begin
        res_status_r <= found_r ? ST_DONE : ST_EMPTY;
      end
    end
    if (state_r == S_TASK) begin
      res_task_r <= TASK_W'(task_rdata);
    end
    if (state_r == S_PUT && out_free) begin
      out_status_r <= res_status_r;
      out_task_r   <= res_task_r;
      out_level_r  <= res_level_r;
    end
  end

`ifndef NO_ASSERTIONS
  // non-empty flag agrees with the stored count of the level being worked on
  a_ne_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_META) && meta_vld_r[lvl_r] |-> ((meta_cur.count != '0) == ne_r[lvl_r]))
    else $error("non-empty flag disagrees with level count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_META) |-> (meta_cur.count <= CNT_W'(QUEUE_DEPTH)))
    else $error("level count above queue depth");

  a_empty_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_META) && (cmd_r == CMD_DISPATCH) && !found_r |-> (ne_r == '0))
    else $error("dispatch reported empty while a level holds tasks");

  a_dispatch_pops_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    deq_go |-> ne_r[lvl_r] && (meta_cur.count != '0))
    else $error("dispatch from an empty level");
`endif

endmodule
